/* hdl/tag_sighting_count_table_assert.svh */
// Assertion macros for the tag sighting count table checker.
// Included by the checker file only.
`ifndef TAG_SIGHTING_COUNT_TABLE_ASSERT_SVH
`define TAG_SIGHTING_COUNT_TABLE_ASSERT_SVH
// Implication checked on every clock, ignored in reset.
`define TSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc check failed");
// Next-cycle implication.
`define TSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc check failed");
`endif

/* hdl/tsc_pkg.sv */
// Package for the tag sighting count table: status codes, actions, entry type.
// No dependencies.
package tsc_pkg;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [10:0] MINUTE_MAX = 11'd1439;

    typedef struct packed {
        logic [31:0]       id;
        logic [15:0]       hits;
        logic [6:0]        first_slot;
        logic [6:0]        last_slot;
        logic signed [7:0] rssi_min;
        logic signed [7:0] rssi_max;
        logic signed [7:0] rssi_avg;
        logic [15:0]       window_mask;
    } t_entry;

    // Cell command, broadcast to the chain.
    typedef struct packed {
        logic shift;   // every cell takes its right neighbor (rotate)
    } t_cell_ctl;
endpackage

/* hdl/tsc_cell.sv */
// One storage cell of the table chain.
// Depends on tsc_pkg.
module tsc_cell (
    input  logic              i_clk,
    input  tsc_pkg::t_cell_ctl i_ctl,
    input  tsc_pkg::t_entry   i_next,
    output tsc_pkg::t_entry   o_entry
);
    import tsc_pkg::*;
    t_entry r_entry;
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end
    assign o_entry = r_entry;
endmodule

/* hdl/tsc_divider.sv */
// Serial signed divider, truncating toward zero (9-bit by 17-bit).
// Depends on tsc_pkg.
module tsc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [8:0] i_num,
    input  logic [16:0]       i_den,
    output logic              o_done,
    output logic signed [8:0] o_quo
);
    import tsc_pkg::*;
    logic [8:0]  r_rem_num, n_rem_num;
    logic [16:0] r_rem, n_rem;
    logic [8:0]  r_quo, n_quo;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [17:0] w_try;

    assign w_try = {r_rem, r_rem_num[8]} - {1'b0, i_den};

    always_comb begin
        n_rem_num = r_rem_num;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_start) begin
            n_rem_num = i_num[8] ? 9'(-i_num) : i_num;
            n_rem     = '0;
            n_quo     = '0;
            n_cnt     = 4'd9;
            n_neg     = i_num[8];
            n_busy    = 1'b1;
        end else if (r_busy) begin
            if (!w_try[17]) begin
                n_rem = w_try[16:0];
                n_quo = {r_quo[7:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_rem_num[8]};
                n_quo = {r_quo[7:0], 1'b0};
            end
            n_rem_num = {r_rem_num[7:0], 1'b0};
            n_cnt     = r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem_num <= n_rem_num;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? 9'(-r_quo) : r_quo;
endmodule

/* hdl/tag_sighting_count_table.sv */
// Tag sighting count table: a rotating chain of entry cells; the sequencer
// watches the head cell while the chain rotates once.
// Read, remove miss and add overflow end after the scan rotation; add miss
// and remove hit add a write-back rotation; add hit runs two divisions, then write-back; clear skips the scan.
// One request at a time; a new request can be accepted in the cycle after the strobe.
// Reset clears count, total and sequencer; entries stay undefined until written.
module tag_sighting_count_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_tag_id,
    input  logic [10:0] i_minute_of_day,
    input  logic signed [7:0] i_rssi,
    input  logic [5:0]  i_entry_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count,
    output logic [31:0] o_sightings_added,
    output logic [31:0] o_out_id,
    output logic [15:0] o_out_hits,
    output logic [6:0]  o_out_first_slot,
    output logic [6:0]  o_out_last_slot,
    output logic signed [7:0] o_out_rssi_min,
    output logic signed [7:0] o_out_rssi_max,
    output logic signed [7:0] o_out_rssi_avg,
    output logic [15:0] o_out_window_mask
);
    import tsc_pkg::*;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NB = (TABLE_DEPTH > 1) ? 1 : 0;
    // reciprocals: slot = mod*1093 >> 14, window = mod*1457 >> 17 (exact to 1439)
    localparam logic [21:0] SLOT_RECIP = 22'd1093;
    localparam logic [21:0] WIN_RECIP  = 22'd1457;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_DIVA = 7'b0000100,
        S_DIVB = 7'b0001000,
        S_FIX  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_pos, n_pos;    // logical index now at head
    logic [CW-1:0] r_rot, n_rot;    // shifts left in this rotation
    logic [31:0] r_total, n_total;
    logic [1:0]  r_act;
    logic [31:0] r_id;
    logic [6:0]  r_slot;
    logic [15:0] r_bit;
    logic signed [7:0] r_rssi;
    logic [6:0]  r_idx;
    logic        r_hit, n_hit;
    logic [CW-1:0] r_hpos, n_hpos;
    t_entry      r_upd, n_upd;
    t_entry      r_rd, n_rd;
    logic        r_rdok, n_rdok;
    logic [1:0]  r_st, n_st;
    logic signed [8:0] r_q1, n_q1;
    logic        r_valid;
    logic        r_drop, n_drop;  // remove: skip head one rotation

    t_cell_ctl   w_ctl;
    t_entry      w_cell [TABLE_DEPTH];
    t_entry      w_head, w_tail_in, w_fresh;
    logic [10:0] w_mod;
    logic [21:0] w_slot_mul, w_win_mul;
    logic        w_accept;
    logic        w_div_start, w_div_done;
    logic signed [8:0] w_div_num, w_div_q;
    logic [16:0] w_div_den;

    assign w_head = w_cell[0];
    assign w_mod  = (i_minute_of_day > MINUTE_MAX) ? MINUTE_MAX : i_minute_of_day;
    assign w_slot_mul = 22'(w_mod) * SLOT_RECIP;
    assign w_win_mul  = 22'(w_mod) * WIN_RECIP;
    assign w_accept = start && !busy;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            t_entry w_nx;
            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign w_nx = w_tail_in;
            end else begin : g_mid
                assign w_nx = w_cell[g+1];
            end
            tsc_cell u_cell (.i_clk(i_clk), .i_ctl(w_ctl), .i_next(w_nx),
                             .o_entry(w_cell[g]));
        end
    endgenerate

    tsc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den), .o_done(w_div_done), .o_quo(w_div_q)
    );

    assign w_div_den   = {1'b0, r_upd.hits};
    assign w_div_start = (r_state == S_DIVA || r_state == S_DIVB) && r_hit;
    assign w_div_num   = (r_state == S_DIVA) ? 9'(r_upd.rssi_avg) : 9'(r_rssi);

    always_comb begin
        w_fresh = '0;
        w_fresh.id = r_id;
        w_fresh.hits = 16'd1;
        w_fresh.first_slot = r_slot;
        w_fresh.last_slot = r_slot;
        w_fresh.rssi_min = r_rssi;
        w_fresh.rssi_max = r_rssi;
        w_fresh.rssi_avg = r_rssi;
        w_fresh.window_mask = r_bit;
    end

    always_comb begin
        logic signed [10:0] v_avg;
        n_state = r_state; n_used = r_used; n_pos = r_pos; n_rot = r_rot;
        n_total = r_total; n_hit = r_hit; n_hpos = r_hpos; n_upd = r_upd;
        n_rd = r_rd; n_rdok = r_rdok; n_st = r_st; n_q1 = r_q1; n_drop = r_drop;
        w_ctl = '0;
        w_tail_in = w_head;
        v_avg = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pos = '0; n_rot = CW'(TABLE_DEPTH); n_hit = 1'b0;
                    n_rdok = 1'b0; n_st = ST_OK; n_drop = 1'b0; n_rd = '0;
                    n_state = S_SCAN;
                    if (i_action == ACT_ADD) n_total = r_total + 32'd1;
                    if (i_action == ACT_CLEAR) begin
                        n_used = '0; n_total = '0; n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                w_ctl.shift = 1'b1;
                if (r_pos < r_used) begin
                    if (r_act == ACT_READ && r_pos == r_idx[CW-1:0]
                        && {1'b0, r_idx} < 8'(r_used)) begin
                        n_rd = w_head; n_rdok = 1'b1;
                    end
                    if ((r_act == ACT_ADD || r_act == ACT_REMOVE) && !r_hit
                        && w_head.id == r_id) begin
                        n_hit = 1'b1; n_hpos = r_pos; n_upd = w_head;
                    end
                end
                n_pos = r_pos + CW'(1);
                n_rot = r_rot - CW'(1);
                if (r_rot == CW'(1)) begin
                    n_pos = '0;
                    n_state = S_DONE;
                    if (r_act == ACT_READ && !n_rdok) n_st = ST_NOT_FOUND;
                    if (r_act == ACT_REMOVE) begin
                        if (n_hit) begin
                            n_drop = 1'b1; n_rot = CW'(TABLE_DEPTH); n_state = S_WB;
                        end else n_st = ST_NOT_FOUND;
                    end
                    if (r_act == ACT_ADD) begin
                        if (n_hit) begin
                            n_upd.hits = (n_upd.hits == 16'hFFFF) ? n_upd.hits
                                                                 : n_upd.hits + 16'd1;
                            n_upd.last_slot = r_slot;
                            if (r_rssi < n_upd.rssi_min) n_upd.rssi_min = r_rssi;
                            if (r_rssi > n_upd.rssi_max) n_upd.rssi_max = r_rssi;
                            n_upd.window_mask = n_upd.window_mask | r_bit;
                            n_state = S_DIVA;
                        end else if (r_used >= CW'(TABLE_DEPTH)) begin
                            n_st = ST_OVERFLOW;
                        end else begin
                            n_upd = w_fresh; n_hpos = r_used;
                            n_used = r_used + CW'(1);
                            n_rot = CW'(TABLE_DEPTH); n_state = S_WB;
                        end
                    end
                end
            end
            S_DIVA: begin
                if (w_div_done) begin
                    n_q1 = w_div_q; n_hit = 1'b1; n_state = S_DIVB;
                end else n_hit = 1'b0;
            end
            S_DIVB: begin
                n_hit = 1'b0;
                if (w_div_done) n_state = S_FIX;
            end
            S_FIX: begin
                v_avg = 11'(r_upd.rssi_avg) - 11'(r_q1) + 11'(w_div_q);
                if (v_avg > 11'sd127) v_avg = 11'sd127;
                if (v_avg < -11'sd128) v_avg = -11'sd128;
                n_upd.rssi_avg = v_avg[7:0];
                n_rot = CW'(TABLE_DEPTH); n_pos = '0; n_state = S_WB;
            end
            S_WB: begin
                // one rotation; on remove every entry past the hit slides down
                w_ctl.shift = 1'b1;
                if (r_drop) begin
                    if (r_pos + CW'(1) < CW'(TABLE_DEPTH) && r_pos >= r_hpos)
                        w_tail_in = w_cell[NB];
                    w_ctl.shift = 1'b1;
                end else if (r_pos == r_hpos) begin
                    w_tail_in = r_upd;
                end
                n_pos = r_pos + CW'(1);
                n_rot = r_rot - CW'(1);
                if (r_rot == CW'(1)) begin
                    n_pos = '0;
                    if (r_drop) begin
                        n_drop = 1'b0; n_used = r_used - CW'(1);
                        n_hpos = '0; n_rot = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_total <= n_total;
            r_valid <= (r_state == S_DONE);
        end
        r_pos <= n_pos; r_rot <= n_rot; r_hit <= n_hit; r_hpos <= n_hpos;
        r_upd <= n_upd; r_rd <= n_rd; r_rdok <= n_rdok; r_st <= n_st;
        r_q1 <= n_q1; r_drop <= n_drop;
        if (r_state == S_IDLE && w_accept) begin
            r_act  <= i_action;
            r_id   <= i_tag_id;
            r_rssi <= i_rssi;
            r_idx  <= {1'b0, i_entry_index};
            r_slot <= w_slot_mul[20:14];
            r_bit  <= 16'd1 << w_win_mul[20:17];
        end
    end

    assign busy = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_status = r_st;
    assign o_entry_count = 7'(r_used);
    assign o_sightings_added = r_total;
    assign o_out_id = r_rdok ? r_rd.id : '0;
    assign o_out_hits = r_rdok ? r_rd.hits : '0;
    assign o_out_first_slot = r_rdok ? r_rd.first_slot : '0;
    assign o_out_last_slot = r_rdok ? r_rd.last_slot : '0;
    assign o_out_rssi_min = r_rdok ? r_rd.rssi_min : '0;
    assign o_out_rssi_max = r_rdok ? r_rd.rssi_max : '0;
    assign o_out_rssi_avg = r_rdok ? r_rd.rssi_avg : '0;
    assign o_out_window_mask = r_rdok ? r_rd.window_mask : '0;
endmodule

/* hdl/tsc_checker.sv */
// Port-level checker for the tag sighting count table, bound to the top level.
// Depends on tag_sighting_count_table_assert.svh.
`include "tag_sighting_count_table_assert.svh"
module tsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [6:0]  o_entry_count
);
    `TSC_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `TSC_ASSERT_IMP(a_valid_while_busy, i_clk, i_rst_n, o_valid, busy)
    `TSC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_valid, o_entry_count <= 7'd64)
    `TSC_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_status != 2'd3)
    `TSC_ASSERT_NXT(a_one_strobe, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind tag_sighting_count_table tsc_checker u_tsc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_status(o_status),
    .o_entry_count(o_entry_count)
);
